### rtl/s27g_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers of the 27-point stencil CSR row generator.
package s27g_pkg;

  localparam int unsigned RowW   = 24;
  localparam int unsigned DimW   = 9;
  localparam int unsigned PlaneW = 2 * DimW;
  localparam int unsigned TotalW = 3 * DimW;
  localparam int unsigned PosW   = 29;
  localparam int unsigned ValW   = 6;
  localparam int unsigned CountW = 5;
  localparam int unsigned CfgIdxW = 2;

  localparam int unsigned MaxDimDef     = 256;
  localparam int unsigned QueueDepthDef = 2;

  localparam logic [DimW-1:0] GridReset = 9'd16;

  localparam logic [CfgIdxW-1:0] CfgGridX = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgGridY = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgGridZ = 2'd2;

  localparam logic signed [ValW-1:0] ValDiag = 6'sd26;
  localparam logic signed [ValW-1:0] ValOff  = -6'sd1;
  localparam logic signed [ValW-1:0] RhsBase = 6'sd26;

  // stencil offset codes per axis
  localparam logic [1:0] OffNeg  = 2'd0;
  localparam logic [1:0] OffZero = 2'd1;
  localparam logic [1:0] OffPos  = 2'd2;

  typedef struct packed {
    logic [DimW-1:0]   nx;
    logic [DimW-1:0]   ny;
    logic [DimW-1:0]   nz;
    logic [PlaneW-1:0] plane;
    logic [TotalW-1:0] total;
  } grid_t;

  // lo_ok/hi_ok: bit 0 x, bit 1 y, bit 2 z
  typedef struct packed {
    logic [RowW-1:0]        row;
    logic                   restart;
    logic                   oor;
    logic [2:0]             lo_ok;
    logic [2:0]             hi_ok;
    logic signed [ValW-1:0] rhs;
  } row_cmd_t;

  typedef struct packed {
    logic [PosW-1:0]        row_start;
    logic [PosW-1:0]        entry_position;
    logic [RowW-1:0]        column_index;
    logic signed [ValW-1:0] entry_value;
    logic signed [ValW-1:0] rhs_value;
    logic                   last;
    logic                   row_out_of_range;
  } result_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_CHECK,
    F_DIVX,
    F_DIVY,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_WALK,
    B_FLAG
  } back_state_e;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v,
                                                input int unsigned max_dim);
    logic [DimW-1:0] r;
    r = v;
    if (v == '0) begin
      r = DimW'(1);
    end else if (32'(v) > max_dim) begin
      r = DimW'(max_dim);
    end
    return r;
  endfunction

  function automatic logic off_ok(input logic [1:0] code, input logic lo, input logic hi);
    logic r;
    case (code)
      OffNeg:  r = lo;
      OffPos:  r = hi;
      default: r = 1'b1;
    endcase
    return r;
  endfunction

endpackage

### rtl/stencil27_csr_row_generator_top.sv
`timescale 1ns / 1ps
// Top level of the 27-point stencil CSR row generator.
//
// Each input transfer names one grid row; the block returns one transfer per
// in-grid stencil neighbor (z, y, x order, last marked by tlast), or a single
// flagged transfer for a row outside the grid. The front end splits the row
// index with a divider that retires two quotient bits per cycle (two 24-bit
// divisions, by nx and then by ny); an out-of-range row skips the divider. The
// back end walks the offsets at one per cycle while the output is free, up to
// the last in-grid one, after loading the row from the queue; an out-of-range
// row yields just its flag. Both run concurrently through a two-entry row
// queue, so the front end can split the next row while the back end still
// walks the last one.
// Input is held off after reset and during and after each configuration
// write.
module stencil27_csr_row_generator_top #(
  parameter int unsigned MaxDim     = s27g_pkg::MaxDimDef,
  parameter int unsigned QueueDepth = s27g_pkg::QueueDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [23:0]                  s_axis_tdata,   // [23:0] row_index
  input  logic                         s_axis_tuser,   // [0] restart
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [28:0] row_start, [57:29] entry_position, [81:58] column_index,
  // [87:82] entry_value, [93:88] rhs_value, [95:94] zero
  output logic [95:0]                  m_axis_tdata,
  output logic                         m_axis_tuser,   // [0] row_out_of_range
  output logic                         m_axis_tlast,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [s27g_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [s27g_pkg::DimW-1:0]    cfg_data_i
);
  import s27g_pkg::*;

  logic [DimW-1:0]   grid_x_q, grid_y_q, grid_z_q;
  logic [PlaneW-1:0] plane_q;
  logic [TotalW-1:0] total_q;
  logic [1:0]        cfg_pend_q;
  logic              cfg_hold;
  grid_t             grid;

  row_cmd_t push_cmd, head_cmd;
  logic     push, pop, full, empty;
  result_t  result;

  assign cfg_ready_o = 1'b1;
  assign cfg_hold    = cfg_valid_i || (cfg_pend_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_x_q   <= GridReset;
      grid_y_q   <= GridReset;
      grid_z_q   <= GridReset;
      cfg_pend_q <= 2'b11;
    end else begin
      cfg_pend_q <= {cfg_pend_q[0], cfg_valid_i};
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgGridX: grid_x_q <= cfg_data_i;
          CfgGridY: grid_y_q <= cfg_data_i;
          CfgGridZ: grid_z_q <= cfg_data_i;
          default:  ;
        endcase
      end
    end
  end

  always_comb begin
    grid.nx    = clamp_dim(grid_x_q, MaxDim);
    grid.ny    = clamp_dim(grid_y_q, MaxDim);
    grid.nz    = clamp_dim(grid_z_q, MaxDim);
    grid.plane = plane_q;
    grid.total = total_q;
  end

  always_ff @(posedge clk_i) begin
    plane_q <= PlaneW'(grid.nx) * PlaneW'(grid.ny);
    total_q <= TotalW'(plane_q) * TotalW'(grid.nz);
  end

  s27g_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .grid_i    (grid),
    .cfg_hold_i(cfg_hold),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .row_i     (s_axis_tdata[RowW-1:0]),
    .restart_i (s_axis_tuser),
    .push_o    (push),
    .cmd_o     (push_cmd),
    .full_i    (full)
  );

  s27g_fifo #(
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .full_o (full),
    .pop_i  (pop),
    .cmd_o  (head_cmd),
    .empty_o(empty)
  );

  s27g_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .grid_i     (grid),
    .empty_i    (empty),
    .cmd_i      (head_cmd),
    .pop_o      (pop),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .result_o   (result)
  );

  assign m_axis_tdata = {2'b00, result.rhs_value, result.entry_value, result.column_index,
                         result.entry_position, result.row_start};
  assign m_axis_tuser = result.row_out_of_range;
  assign m_axis_tlast = result.last;

`ifndef SYNTHESIS
  a_flag_is_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata == '0))
    else $error("out-of-range result carries data or lacks tlast");
`endif

endmodule

### rtl/s27g_div.sv
`timescale 1ns / 1ps
// Iterative restoring divider, two quotient bits per cycle.
module s27g_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [s27g_pkg::RowW-1:0] dividend_i,
  input  logic [s27g_pkg::DimW-1:0] divisor_i,
  output logic                      done_o,
  output logic [s27g_pkg::RowW-1:0] quotient_o,
  output logic [s27g_pkg::DimW-1:0] remainder_o
);
  import s27g_pkg::*;

  localparam int unsigned Steps = RowW / 2;
  localparam int unsigned StepW = $clog2(Steps + 1);

  logic             busy_q, done_q;
  logic [StepW-1:0] step_q;
  logic [RowW-1:0]  num_q, num_c;
  logic [DimW-1:0]  rem_q, rem_c, div_q;
  logic [DimW:0]    trial;

  always_comb begin
    rem_c = rem_q;
    num_c = num_q;
    trial = '0;
    for (int i = 0; i < 2; i++) begin
      trial = {rem_c, num_c[RowW-1]};
      num_c = {num_c[RowW-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        trial    = trial - {1'b0, div_q};
        num_c[0] = 1'b1;
      end
      rem_c = trial[DimW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q && (step_q == StepW'(Steps - 1));
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + StepW'(1);
        if (step_q == StepW'(Steps - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      num_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      num_q <= num_c;
      rem_q <= rem_c;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = num_q;
  assign remainder_o = rem_q;

endmodule

### rtl/s27g_front.sv
`timescale 1ns / 1ps
// Front end: takes row transfers, range check, coordinate split, queue push.
module s27g_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  s27g_pkg::grid_t           grid_i,
  input  logic                      cfg_hold_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [s27g_pkg::RowW-1:0] row_i,
  input  logic                      restart_i,
  output logic                      push_o,
  output s27g_pkg::row_cmd_t        cmd_o,
  input  logic                      full_i
);
  import s27g_pkg::*;

  front_state_e state_q, state_d;

  logic [RowW-1:0] row_q;
  logic            restart_q, oor_q;
  logic [DimW-1:0] ix_q, iy_q, iz_q;
  logic            in_range;

  logic            div_start, div_done;
  logic [RowW-1:0] div_dividend, div_quot;
  logic [DimW-1:0] div_divisor, div_rem;

  logic [2:0]        lo_ok, hi_ok;
  logic [1:0]        cx, cy, cz;
  logic [3:0]        cxy;
  logic [CountW-1:0] count;

  assign in_range = TotalW'(row_q) < grid_i.total;

  s27g_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot),
    .remainder_o(div_rem)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE:  if (in_valid_i && in_ready_o) state_d = F_CHECK;
      F_CHECK: state_d = in_range ? F_DIVX : F_PUSH;
      F_DIVX:  if (div_done) state_d = F_DIVY;
      F_DIVY:  if (div_done) state_d = F_PUSH;
      F_PUSH:  if (!full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    push_o       = 1'b0;
    div_start    = 1'b0;
    div_dividend = row_q;
    div_divisor  = grid_i.nx;
    case (state_q)
      F_IDLE:  in_ready_o = !cfg_hold_i;
      F_CHECK: div_start = in_range;
      F_DIVX: begin
        div_start    = div_done;
        div_dividend = div_quot;
        div_divisor  = grid_i.ny;
      end
      F_PUSH:  push_o = !full_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && in_valid_i && in_ready_o) begin
      row_q     <= row_i;
      restart_q <= restart_i;
    end
    if (state_q == F_CHECK) begin
      oor_q <= !in_range;
    end
    if (state_q == F_DIVX && div_done) begin
      ix_q <= div_rem;
    end
    if (state_q == F_DIVY && div_done) begin
      iy_q <= div_rem;
      iz_q <= div_quot[DimW-1:0];
    end
  end

  always_comb begin
    lo_ok[0] = ix_q != '0;
    lo_ok[1] = iy_q != '0;
    lo_ok[2] = iz_q != '0;
    hi_ok[0] = ({1'b0, ix_q} + (DimW + 1)'(1)) < {1'b0, grid_i.nx};
    hi_ok[1] = ({1'b0, iy_q} + (DimW + 1)'(1)) < {1'b0, grid_i.ny};
    hi_ok[2] = ({1'b0, iz_q} + (DimW + 1)'(1)) < {1'b0, grid_i.nz};
    cx    = 2'd1 + {1'b0, lo_ok[0]} + {1'b0, hi_ok[0]};
    cy    = 2'd1 + {1'b0, lo_ok[1]} + {1'b0, hi_ok[1]};
    cz    = 2'd1 + {1'b0, lo_ok[2]} + {1'b0, hi_ok[2]};
    cxy   = {2'b00, cx} * {2'b00, cy};
    count = {1'b0, cxy} * {3'b000, cz};
    cmd_o.row     = row_q;
    cmd_o.restart = restart_q;
    cmd_o.oor     = oor_q;
    cmd_o.lo_ok   = lo_ok;
    cmd_o.hi_ok   = hi_ok;
    cmd_o.rhs     = RhsBase - $signed({1'b0, count});
  end

`ifndef SYNTHESIS
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == F_DIVX || state_q == F_DIVY))
    else $error("divider finished outside a divide state");
  a_push_after_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == F_CHECK && !in_range) |=> (state_q == F_PUSH && oor_q))
    else $error("out-of-range row not flagged");
`endif

endmodule

### rtl/s27g_fifo.sv
`timescale 1ns / 1ps
// Short queue of classified rows between front and back end.
module s27g_fifo #(
  parameter int unsigned Depth = s27g_pkg::QueueDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  s27g_pkg::row_cmd_t cmd_i,
  output logic               full_o,
  input  logic               pop_i,
  output s27g_pkg::row_cmd_t cmd_o,
  output logic               empty_o
);
  import s27g_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  row_cmd_t        entries_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = count_q == CntW'(Depth);
  assign empty_o = count_q == '0;
  assign cmd_o   = entries_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wptr_q] <= cmd_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");
`endif

endmodule

### rtl/s27g_back.sv
`timescale 1ns / 1ps
// Back end: walks a row's stencil offsets up to the last in-grid one and emits CSR entries or an out-of-range flag.
module s27g_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  s27g_pkg::grid_t      grid_i,
  input  logic                 empty_i,
  input  s27g_pkg::row_cmd_t   cmd_i,
  output logic                 pop_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output s27g_pkg::result_t    result_o
);
  import s27g_pkg::*;

  back_state_e state_q, state_d;

  row_cmd_t        cmd_q;
  logic [1:0]      xc_q, yc_q, zc_q;
  logic [PosW-1:0] next_q, row_start_q;
  logic            out_valid_q;
  result_t         out_q;

  logic            out_free, cur_ok, cur_last, diag, emit, step;
  logic [1:0]      xlast, ylast, zlast;
  logic [RowW-1:0] xoff, yoff, zoff, col;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    xlast    = cmd_q.hi_ok[0] ? OffPos : OffZero;
    ylast    = cmd_q.hi_ok[1] ? OffPos : OffZero;
    zlast    = cmd_q.hi_ok[2] ? OffPos : OffZero;
    cur_ok   = off_ok(xc_q, cmd_q.lo_ok[0], cmd_q.hi_ok[0]) &&
               off_ok(yc_q, cmd_q.lo_ok[1], cmd_q.hi_ok[1]) &&
               off_ok(zc_q, cmd_q.lo_ok[2], cmd_q.hi_ok[2]);
    cur_last = (xc_q == xlast) && (yc_q == ylast) && (zc_q == zlast);
    diag     = (xc_q == OffZero) && (yc_q == OffZero) && (zc_q == OffZero);
  end

  always_comb begin
    case (xc_q)
      OffNeg:  xoff = '1;
      OffPos:  xoff = RowW'(1);
      default: xoff = '0;
    endcase
    case (yc_q)
      OffNeg:  yoff = -RowW'(grid_i.nx);
      OffPos:  yoff = RowW'(grid_i.nx);
      default: yoff = '0;
    endcase
    case (zc_q)
      OffNeg:  zoff = -RowW'(grid_i.plane);
      OffPos:  zoff = RowW'(grid_i.plane);
      default: zoff = '0;
    endcase
    col = cmd_q.row + xoff + yoff + zoff;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE:  if (!empty_i) state_d = cmd_i.oor ? B_FLAG : B_WALK;
      B_WALK:  if (out_free && cur_ok && cur_last) state_d = B_IDLE;
      B_FLAG:  if (out_free) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    pop_o = 1'b0;
    emit  = 1'b0;
    step  = 1'b0;
    case (state_q)
      B_IDLE:  pop_o = !empty_i;
      B_WALK: begin
        step = out_free;
        emit = out_free && cur_ok;
      end
      B_FLAG:  emit = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
      next_q      <= '0;
      xc_q        <= OffNeg;
      yc_q        <= OffNeg;
      zc_q        <= OffNeg;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (pop_o && cmd_i.restart) begin
        next_q <= '0;
      end else if (emit && state_q == B_WALK) begin
        next_q <= next_q + PosW'(1);
      end
      if (pop_o) begin
        xc_q <= OffNeg;
        yc_q <= OffNeg;
        zc_q <= OffNeg;
      end else if (step) begin
        if (xc_q != OffPos) begin
          xc_q <= xc_q + 2'd1;
        end else begin
          xc_q <= OffNeg;
          if (yc_q != OffPos) begin
            yc_q <= yc_q + 2'd1;
          end else begin
            yc_q <= OffNeg;
            zc_q <= zc_q + 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q       <= cmd_i;
      row_start_q <= cmd_i.restart ? '0 : next_q;
    end
    if (emit) begin
      if (state_q == B_FLAG) begin
        out_q <= '{last: 1'b1, row_out_of_range: 1'b1, default: '0};
      end else begin
        out_q.row_start        <= row_start_q;
        out_q.entry_position   <= next_q;
        out_q.column_index     <= col;
        out_q.entry_value      <= diag ? ValDiag : ValOff;
        out_q.rhs_value        <= cmd_q.rhs;
        out_q.last             <= cur_last;
        out_q.row_out_of_range <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

`ifndef SYNTHESIS
  a_diag_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_WALK && diag) |-> cur_ok)
    else $error("diagonal offset judged outside the grid");
  a_walk_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_WALK && xc_q == OffPos && yc_q == OffPos && zc_q == OffPos)
      |-> (cur_ok && cur_last))
    else $error("offset walk ran past the final entry");
`endif

endmodule
